>>> rtl/fne2e_pkg.sv
// Shared types, constants and rounding helpers for the facet normal block.
`timescale 1ns / 1ps

package fne2e_pkg;

	// Widths fixed by the beat layout.
	localparam int IDX_W    = 10;
	localparam int FIELD_W  = 24;
	localparam int Q30_W    = 32;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 96;

	// Defaults for the top-level parameters.
	localparam int DEF_VERTEX_DEPTH = 1024;
	localparam int DEF_FACET_DEPTH  = 1024;
	localparam int DEF_COORD_WIDTH  = 24;

	localparam logic signed [Q30_W-1:0] ONE_Q30 = 32'sh4000_0000;

	typedef enum logic [1:0] {
		CMD_WR_VERTEX = 2'd0,
		CMD_WR_FACET  = 2'd1,
		CMD_COMPUTE   = 2'd2,
		CMD_UNUSED    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SIN_LAT = 2'd0,
		REG_COS_LAT = 2'd1,
		REG_SIN_LON = 2'd2,
		REG_COS_LON = 2'd3
	} reg_idx_t;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_RD_F  = 16'h0002,
		ST_RD_A  = 16'h0004,
		ST_RD_B  = 16'h0008,
		ST_RD_C  = 16'h0010,
		ST_EDGE  = 16'h0020,
		ST_XMUL  = 16'h0040,
		ST_ABSV  = 16'h0080,
		ST_SCALE = 16'h0100,
		ST_SQ    = 16'h0200,
		ST_SQRT  = 16'h0400,
		ST_DIV   = 16'h0800,
		ST_COEF  = 16'h1000,
		ST_ROT   = 16'h2000,
		ST_FIN   = 16'h4000,
		ST_DONE  = 16'h8000
	} state_t;

	// Limit a Q1.30 register value to [-1, 1].
	function automatic logic signed [Q30_W-1:0] clamp_q30(input logic signed [Q30_W-1:0] v);
		logic signed [Q30_W-1:0] r;
		if (v > ONE_Q30) r = ONE_Q30;
		else if (v < -ONE_Q30) r = -ONE_Q30;
		else r = v;
		return r;
	endfunction

	// Round v / 2^30 to nearest, ties away from zero, saturated to [-2^30, 2^30].
	function automatic logic signed [Q30_W-1:0] rnd_sat_q30(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] sum;
		logic [33:0] m;
		logic [Q30_W-1:0] ms;
		mag = v[63] ? (64'd0 - v) : v;
		sum = mag + 64'h2000_0000;
		m = sum[63:30];
		if (m > 34'h4000_0000) ms = ONE_Q30;
		else ms = m[Q30_W-1:0];
		return v[63] ? -$signed(ms) : $signed(ms);
	endfunction

endpackage

>>> rtl/facet_normal_enu_to_ecef_core.sv
// Facet normal engine: vertex and facet stores, cross product, normalize, ENU to ECEF.
`timescale 1ns / 1ps

// Vertex and facet writes are stored when accepted. A compute reads the stores, then works
// through one shared multiplier, a 32-step square root, three divisions and block scaling
// at one bit per cycle. A zero-length normal returns a degenerate zero result. One item is
// in work at a time; s_tready is high only when idle, so a new beat is not taken until the
// last result has been loaded into the output register.
// Reset clears the sequencer and output valid and sets the trig registers to sin 0, cos 1.
module facet_normal_enu_to_ecef_core import fne2e_pkg::*; #(
	parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
	parameter int FACET_DEPTH  = DEF_FACET_DEPTH,
	parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [Q30_W-1:0]      cfg_data,
	// Input beats.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vertex_index[9:0], east[33:10], north[57:34], up[81:58], facet_idx[91:82],
	// corner_a[101:92], corner_b[111:102], corner_c[121:112], zero pad[127:122]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [1:0]            s_tuser,
	// Result beats.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// normal_x[31:0], normal_y[63:32], normal_z[95:64]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// degenerate[0]
	output logic                  m_tuser
);

	localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int FAW = (FACET_DEPTH > 1) ? $clog2(FACET_DEPTH) : 1;
	localparam int CW  = COORD_WIDTH;
	localparam int EW  = CW + 1;
	localparam int MW  = (EW > Q30_W) ? EW : Q30_W;
	localparam int PW  = 2 * MW;
	localparam int NW  = 2 * CW + 3;
	localparam int MGW = (NW > 31) ? NW : 31;

	// Operand extension to the multiplier width.
	function automatic logic signed [MW-1:0] ext_e(input logic [EW-1:0] x);
		logic [EW+MW-1:0] t;
		t = {{MW{x[EW-1]}}, x};
		return t[MW-1:0];
	endfunction

	function automatic logic signed [MW-1:0] ext_q(input logic [Q30_W-1:0] x);
		logic [Q30_W+MW-1:0] t;
		t = {{MW{x[Q30_W-1]}}, x};
		return t[MW-1:0];
	endfunction

	function automatic logic signed [MW-1:0] ext_u(input logic [29:0] x);
		logic [30+MW-1:0] t;
		t = {{MW{1'b0}}, x};
		return t[MW-1:0];
	endfunction

	// Field unpacking.
	cmd_t             in_cmd;
	logic [IDX_W-1:0] in_vi, in_fi, in_ca, in_cb, in_cc;
	logic [FIELD_W-1:0] in_east, in_north, in_up;

	assign in_cmd   = cmd_t'(s_tuser);
	assign in_vi    = s_tdata[9:0];
	assign in_east  = s_tdata[33:10];
	assign in_north = s_tdata[57:34];
	assign in_up    = s_tdata[81:58];
	assign in_fi    = s_tdata[91:82];
	assign in_ca    = s_tdata[101:92];
	assign in_cb    = s_tdata[111:102];
	assign in_cc    = s_tdata[121:112];

	state_t state_q;
	logic [5:0] cnt_q;
	logic [1:0] k_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Index conversion and range checks.
	logic [IDX_W+VAW-1:0] vi_ext;
	logic [IDX_W+FAW-1:0] fi_ext;
	logic [VAW-1:0]       vi_addr;
	logic [FAW-1:0]       fi_addr;
	logic                 vi_ok, fi_ok;
	logic [FIELD_W+CW-1:0] east_ext, north_ext, up_ext;

	assign vi_ext   = {{VAW{1'b0}}, in_vi};
	assign fi_ext   = {{FAW{1'b0}}, in_fi};
	assign vi_addr  = vi_ext[VAW-1:0];
	assign fi_addr  = fi_ext[FAW-1:0];
	assign vi_ok    = (32'(in_vi) < 32'(VERTEX_DEPTH));
	assign fi_ok    = (32'(in_fi) < 32'(FACET_DEPTH));
	assign east_ext  = {{CW{1'b0}}, in_east};
	assign north_ext = {{CW{1'b0}}, in_north};
	assign up_ext    = {{CW{1'b0}}, in_up};

	// Configuration registers.
	logic signed [Q30_W-1:0] sin_lat_q, cos_lat_q, sin_lon_q, cos_lon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_lat_q <= '0;
			cos_lat_q <= ONE_Q30;
			sin_lon_q <= '0;
			cos_lon_q <= ONE_Q30;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SIN_LAT: sin_lat_q <= cfg_data;
				REG_COS_LAT: cos_lat_q <= cfg_data;
				REG_SIN_LON: sin_lon_q <= cfg_data;
				REG_COS_LON: cos_lon_q <= cfg_data;
			endcase
		end
	end

	logic signed [Q30_W-1:0] sp, cp, sl, cl, nsp, nsl;

	assign sp  = clamp_q30(sin_lat_q);
	assign cp  = clamp_q30(cos_lat_q);
	assign sl  = clamp_q30(sin_lon_q);
	assign cl  = clamp_q30(cos_lon_q);
	assign nsp = -sp;
	assign nsl = -sl;

	// Stores, written on accepted write beats and read with a registered port.
	logic [CW-1:0]      east_mem  [VERTEX_DEPTH];
	logic [CW-1:0]      north_mem [VERTEX_DEPTH];
	logic [CW-1:0]      up_mem    [VERTEX_DEPTH];
	logic [3*IDX_W-1:0] facet_mem [FACET_DEPTH];

	logic [FAW-1:0]     fi_addr_q;
	logic [3*IDX_W-1:0] fdata_q;
	logic [IDX_W-1:0]   corner;
	logic [IDX_W+VAW-1:0] corner_ext;
	logic [VAW-1:0]     vrd_addr;
	logic               vrd_ok;
	logic [CW-1:0]      vrd_e_q, vrd_n_q, vrd_u_q;
	logic               vrd_ok_q;

	always_comb begin
		if (state_q == ST_RD_A) corner = fdata_q[IDX_W-1:0];
		else if (state_q == ST_RD_B) corner = fdata_q[2*IDX_W-1:IDX_W];
		else corner = fdata_q[3*IDX_W-1:2*IDX_W];
	end

	assign corner_ext = {{VAW{1'b0}}, corner};
	assign vrd_addr   = corner_ext[VAW-1:0];
	assign vrd_ok     = (32'(corner) < 32'(VERTEX_DEPTH));

	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_WR_VERTEX && vi_ok) begin
			east_mem[vi_addr]  <= east_ext[CW-1:0];
			north_mem[vi_addr] <= north_ext[CW-1:0];
			up_mem[vi_addr]    <= up_ext[CW-1:0];
		end
		if (accept && in_cmd == CMD_WR_FACET && fi_ok) begin
			facet_mem[fi_addr] <= {in_cc, in_cb, in_ca};
		end
		fdata_q  <= facet_mem[fi_addr_q];
		vrd_e_q  <= east_mem[vrd_addr];
		vrd_n_q  <= north_mem[vrd_addr];
		vrd_u_q  <= up_mem[vrd_addr];
		vrd_ok_q <= vrd_ok;
	end

	// The vertex just read; a corner beyond the store reads as the origin.
	logic [CW-1:0] vcur [3];

	assign vcur[0] = vrd_ok_q ? vrd_e_q : '0;
	assign vcur[1] = vrd_ok_q ? vrd_n_q : '0;
	assign vcur[2] = vrd_ok_q ? vrd_u_q : '0;

	// Datapath registers.
	logic [CW-1:0]            va_q [3];
	logic [CW-1:0]            vb_q [3];
	logic [EW-1:0]            e1_q [3];
	logic [EW-1:0]            e2_q [3];
	logic [NW-1:0]            n_q  [3];
	logic [MGW-1:0]           m_q  [3];
	logic [2:0]               sgn_q;
	logic [63:0]              s_q;
	logic [63:0]              rem_q, res_q, bit_q;
	logic [31:0]              dv_rem_q, dv_low_q, dv_quo_q;
	logic signed [Q30_W-1:0]  u_q    [3];
	logic signed [Q30_W-1:0]  coef_q [4];
	logic signed [63:0]       acc_q  [3];
	logic signed [Q30_W-1:0]  res_o_q [3];
	logic                     res_deg_q;
	logic signed [PW-1:0]     prod_q;
	logic [OUT_DATA_W-1:0]    m_data_q;
	logic                     m_user_q;

	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;

	// Shared multiplier operand selection.
	logic signed [MW-1:0] op_a, op_b;
	logic [1:0]           sq_idx;

	assign sq_idx = (cnt_q < 6'd3) ? cnt_q[1:0] : 2'd0;

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_XMUL: begin
				unique case (cnt_q)
					6'd0: begin op_a = ext_e(e1_q[1]); op_b = ext_e(e2_q[2]); end
					6'd1: begin op_a = ext_e(e1_q[2]); op_b = ext_e(e2_q[1]); end
					6'd2: begin op_a = ext_e(e1_q[2]); op_b = ext_e(e2_q[0]); end
					6'd3: begin op_a = ext_e(e1_q[0]); op_b = ext_e(e2_q[2]); end
					6'd4: begin op_a = ext_e(e1_q[0]); op_b = ext_e(e2_q[1]); end
					6'd5: begin op_a = ext_e(e1_q[1]); op_b = ext_e(e2_q[0]); end
					default: ;
				endcase
			end
			ST_SQ: begin
				op_a = ext_u(m_q[sq_idx][29:0]);
				op_b = ext_u(m_q[sq_idx][29:0]);
			end
			ST_COEF: begin
				unique case (cnt_q)
					6'd0: begin op_a = ext_q(nsp); op_b = ext_q(cl); end
					6'd1: begin op_a = ext_q(cp);  op_b = ext_q(cl); end
					6'd2: begin op_a = ext_q(nsp); op_b = ext_q(sl); end
					6'd3: begin op_a = ext_q(cp);  op_b = ext_q(sl); end
					default: ;
				endcase
			end
			ST_ROT: begin
				unique case (cnt_q)
					6'd0: begin op_a = ext_q(nsl);       op_b = ext_q(u_q[0]); end
					6'd1: begin op_a = ext_q(coef_q[0]); op_b = ext_q(u_q[1]); end
					6'd2: begin op_a = ext_q(coef_q[1]); op_b = ext_q(u_q[2]); end
					6'd3: begin op_a = ext_q(cl);        op_b = ext_q(u_q[0]); end
					6'd4: begin op_a = ext_q(coef_q[2]); op_b = ext_q(u_q[1]); end
					6'd5: begin op_a = ext_q(coef_q[3]); op_b = ext_q(u_q[2]); end
					6'd6: begin op_a = ext_q(cp);        op_b = ext_q(u_q[1]); end
					6'd7: begin op_a = ext_q(sp);        op_b = ext_q(u_q[2]); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Product views and per-step helpers.
	logic [NW+PW-1:0] prod_wide;
	logic [NW-1:0]    prod_n;
	logic [63:0]      prod64;
	logic [5:0]       j;
	logic [1:0]       rot_row;
	logic [63:0]      s_next;
	logic [63:0]      sq_try;
	logic [31:0]      r_val;
	logic [61:0]      dv_num;
	logic [32:0]      dv_try;
	logic             dv_bit;
	logic [31:0]      quo_next;
	logic             n_zero, m_big, m_mid;
	logic [MGW-1:0]   n_abs [3];
	logic [NW+MGW-1:0] n_wide [3];

	assign prod_wide = {{NW{prod_q[PW-1]}}, prod_q};
	assign prod_n    = prod_wide[NW-1:0];
	assign prod64    = prod_q[63:0];
	assign j         = cnt_q - 6'd1;
	assign rot_row   = (j < 6'd3) ? 2'd0 : ((j < 6'd6) ? 2'd1 : 2'd2);
	assign s_next    = s_q + prod64;
	assign sq_try    = res_q + bit_q;
	assign r_val     = res_q[31:0];
	// Dividend is the scaled magnitude times 2^31 plus half the divisor.
	assign dv_num    = {1'b0, m_q[k_q][29:0], 31'd0} + {31'd0, r_val[31:1]};
	assign dv_try    = {dv_rem_q, dv_low_q[31]};
	assign dv_bit    = (dv_try >= {1'b0, r_val});
	assign quo_next  = {dv_quo_q[30:0], dv_bit};
	assign n_zero    = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
	assign m_big     = (m_q[0][MGW-1:30] != '0) || (m_q[1][MGW-1:30] != '0) ||
		(m_q[2][MGW-1:30] != '0);
	assign m_mid     = m_q[0][29] || m_q[1][29] || m_q[2][29];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_wide[i] = {{MGW{n_q[i][NW-1]}}, n_q[i]};
			n_abs[i]  = n_q[i][NW-1] ? (MGW'(0) - n_wide[i][MGW-1:0]) : n_wide[i][MGW-1:0];
		end
	end

	// Datapath steps, driven by the sequencer state.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (accept && in_cmd == CMD_COMPUTE) begin
			fi_addr_q <= fi_addr;
			res_o_q[0] <= '0;
			res_o_q[1] <= '0;
			res_o_q[2] <= '0;
			res_deg_q  <= 1'b1;
		end
		unique case (state_q)
			ST_RD_B: for (int i = 0; i < 3; i++) va_q[i] <= vcur[i];
			ST_RD_C: for (int i = 0; i < 3; i++) vb_q[i] <= vcur[i];
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= {vb_q[i][CW-1], vb_q[i]} - {va_q[i][CW-1], va_q[i]};
					e2_q[i] <= {vcur[i][CW-1], vcur[i]} - {va_q[i][CW-1], va_q[i]};
				end
			end
			ST_XMUL: begin
				// Each component is an even product minus the odd one after it.
				if (cnt_q != 6'd0) begin
					if (!j[0]) n_q[j[2:1]] <= prod_n;
					else n_q[j[2:1]] <= n_q[j[2:1]] - prod_n;
				end
			end
			ST_ABSV: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= n_abs[i];
					sgn_q[i] <= n_q[i][NW-1];
				end
			end
			ST_SCALE: begin
				// Bring the largest magnitude to exactly 30 bits, one bit a cycle.
				if (m_big) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!m_mid) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end
			end
			ST_SQ: begin
				if (cnt_q == 6'd1) s_q <= prod64;
				else if (cnt_q != 6'd0) s_q <= s_next;
				if (cnt_q == 6'd3) begin
					rem_q <= {s_next[61:0], 2'b00};
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			ST_SQRT: begin
				if (rem_q >= sq_try) begin
					rem_q <= rem_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV: begin
				if (cnt_q == 6'd0) begin
					dv_rem_q <= {2'b00, dv_num[61:32]};
					dv_low_q <= dv_num[31:0];
					dv_quo_q <= '0;
				end else begin
					dv_rem_q <= dv_bit ? 32'(dv_try - {1'b0, r_val}) : dv_try[31:0];
					dv_low_q <= dv_low_q << 1;
					dv_quo_q <= quo_next;
					if (cnt_q == 6'd32) u_q[k_q] <= sgn_q[k_q] ? -$signed(quo_next) :
						$signed(quo_next);
				end
			end
			ST_COEF: begin
				if (cnt_q != 6'd0) coef_q[j[1:0]] <= rnd_sat_q30(prod64);
				if (cnt_q == 6'd4) begin
					acc_q[0] <= '0;
					acc_q[1] <= '0;
					acc_q[2] <= '0;
				end
			end
			ST_ROT: begin
				if (cnt_q != 6'd0) acc_q[rot_row] <= acc_q[rot_row] + $signed(prod64);
			end
			ST_FIN: begin
				for (int i = 0; i < 3; i++) res_o_q[i] <= rnd_sat_q30(acc_q[i]);
				res_deg_q <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			m_data_q <= {res_o_q[2], res_o_q[1], res_o_q[0]};
			m_user_q <= res_deg_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 6'd1;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && in_cmd == CMD_COMPUTE) state_q <= fi_ok ? ST_RD_F : ST_DONE;
				end
				ST_RD_F: state_q <= ST_RD_A;
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: state_q <= ST_EDGE;
				ST_EDGE: begin
					state_q <= ST_XMUL;
					cnt_q   <= '0;
				end
				ST_XMUL: if (cnt_q == 6'd6) state_q <= ST_ABSV;
				ST_ABSV: state_q <= n_zero ? ST_DONE : ST_SCALE;
				ST_SCALE: begin
					cnt_q <= '0;
					if (!m_big && m_mid) state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (cnt_q == 6'd3) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'd31) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						k_q     <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == 6'd32) begin
						cnt_q <= '0;
						k_q   <= k_q + 2'd1;
						if (k_q == 2'd2) state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					if (cnt_q == 6'd4) begin
						state_q <= ST_ROT;
						cnt_q   <= '0;
					end
				end
				ST_ROT: if (cnt_q == 6'd8) state_q <= ST_FIN;
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
			endcase

			// The output register holds a beat until it is taken.
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> tb/sv/tb_facet_normal_enu_to_ecef_core.sv
// Self-checking testbench for the facet normal ENU to ECEF core.
`timescale 1ns / 1ps

module tb_facet_normal_enu_to_ecef_core;
	import fne2e_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        deg;
	} normal_t;

	typedef struct {
		cmd_t        cmd;
		logic [9:0]  vi;
		logic [23:0] ea, no, up;
		logic [9:0]  fi, ca, cb, cc;
		bit          typed;
		normal_t     want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [Q30_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	facet_normal_enu_to_ecef_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the stores and the trig registers.
	logic signed [127:0] vtx_store[1024][3];
	logic [29:0] facet_store[1024];
	bit vtx_written[1024];
	bit facet_written[1024];
	logic signed [31:0] trig_reg[4];
	int written_vtx[$];

	normal_t pending_normals[$];
	dir_row_t dir_rows[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int degenerate_seen = 0;
	int s_idle_pct = 33;
	int r_idle_pct = 68;
	int stall_cycles = 0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] res, trial;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = res | (64'd1 << i);
			if (trial * trial <= x) res = trial;
		end
		return res;
	endfunction

	// Divide by 2^30 with rounding to nearest, ties away from zero.
	function automatic logic signed [127:0] round_q30(input logic signed [127:0] v);
		logic [127:0] mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (128'd1 << 29)) >> 30;
		return v < 0 ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [127:0] trig_clamped(input int idx);
		logic signed [127:0] v;
		v = trig_reg[idx];
		if (v > (128'sd1 <<< 30)) v = 128'sd1 <<< 30;
		if (v < -(128'sd1 <<< 30)) v = -(128'sd1 <<< 30);
		return v;
	endfunction

	function automatic logic [31:0] to_output(input logic signed [127:0] acc);
		logic signed [127:0] v;
		v = round_q30(acc);
		if (v > (128'sd1 <<< 30)) v = 128'sd1 <<< 30;
		if (v < -(128'sd1 <<< 30)) v = -(128'sd1 <<< 30);
		return v[31:0];
	endfunction

	// Unit normal of a stored facet, rotated into ECEF.
	function automatic normal_t predict_normal(input logic [9:0] fi);
		normal_t res;
		logic [9:0] ia, ib, ic;
		logic signed [127:0] e1[3], e2[3], n[3], u[3];
		logic [127:0] m[3], mx, sm[3], s, r, q;
		logic signed [127:0] sp, cp, sl, cl;
		int bits;
		res = '{x: 0, y: 0, z: 0, deg: 1'b1};
		ia = facet_store[fi][9:0];
		ib = facet_store[fi][19:10];
		ic = facet_store[fi][29:20];
		for (int k = 0; k < 3; k++) begin
			e1[k] = vtx_store[ib][k] - vtx_store[ia][k];
			e2[k] = vtx_store[ic][k] - vtx_store[ia][k];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
		mx = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = n[k] < 0 ? -n[k] : n[k];
			if (m[k] > mx) mx = m[k];
		end
		bits = 0;
		for (int i = 0; i < 128; i++)
			if (mx[i]) bits = i + 1;
		if (bits == 0) return res;
		// Common block scaling so the largest component has 30 bits.
		s = 0;
		for (int k = 0; k < 3; k++) begin
			sm[k] = bits > 30 ? m[k] >> (bits - 30) : m[k] << (30 - bits);
			s += sm[k] * sm[k];
		end
		r = int_sqrt(s[61:0] << 2);
		for (int k = 0; k < 3; k++) begin
			q = ((sm[k] << 31) + (r >> 1)) / r;
			u[k] = n[k] < 0 ? -$signed(q) : $signed(q);
		end
		sp = trig_clamped(REG_SIN_LAT);
		cp = trig_clamped(REG_COS_LAT);
		sl = trig_clamped(REG_SIN_LON);
		cl = trig_clamped(REG_COS_LON);
		res.x = to_output(-sl * u[0] + round_q30(-sp * cl) * u[1] + round_q30(cp * cl) * u[2]);
		res.y = to_output(cl * u[0] + round_q30(-sp * sl) * u[1] + round_q30(cp * sl) * u[2]);
		res.z = to_output(cp * u[1] + sp * u[2]);
		res.deg = 1'b0;
		return res;
	endfunction

	// Update the shadow state for one accepted beat; queue the expected normal.
	task automatic apply_beat(input cmd_t cmd, input logic [IN_DATA_W-1:0] d,
			input bit typed, input normal_t want);
		logic [9:0] vi, fi;
		vi = d[9:0];
		fi = d[91:82];
		case (cmd)
			CMD_WR_VERTEX: begin
				vtx_store[vi][0] = $signed(d[33:10]);
				vtx_store[vi][1] = $signed(d[57:34]);
				vtx_store[vi][2] = $signed(d[81:58]);
				if (!vtx_written[vi]) written_vtx = {written_vtx, int'(vi)};
				vtx_written[vi] = 1;
			end
			CMD_WR_FACET: begin
				facet_store[fi] = d[121:92];
				facet_written[fi] = 1;
			end
			CMD_COMPUTE: begin
				pending_normals = {pending_normals, (typed ? want : predict_normal(fi))};
			end
			default: ;
		endcase
	endtask

	// Drive one beat; valid stays high between back-to-back beats.
	task automatic send_beat(input cmd_t cmd, input logic [IN_DATA_W-1:0] d,
			input bit typed = 0, input normal_t want = '0);
		if ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < s_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		apply_beat(cmd, d, typed, want);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [IN_DATA_W-1:0] pack_beat(input logic [9:0] vi,
			input logic [23:0] ea, no, up, input logic [9:0] fi, ca, cb, cc);
		return {6'b0, cc, cb, ca, fi, up, no, ea, vi};
	endfunction

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		wait (pending_normals.size() == 0);
		repeat (10) @(negedge clk);
		while (!s_tready) @(negedge clk);
	endtask

	task automatic write_trig(input logic [31:0] sla, cla, slo, clo);
		logic [31:0] vals[4];
		vals = '{sla, cla, slo, clo};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			trig_reg[i] = vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2047) - 1024;
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return $urandom_range(200000) - 100000;
		endcase
	endfunction

	function automatic logic [9:0] pick_corner();
		if (written_vtx.size() > 0 && $urandom_range(99) < 85)
			return written_vtx[$urandom_range(written_vtx.size() - 1)];
		return $urandom;
	endfunction

	function automatic bit facet_usable(input logic [9:0] fi);
		return facet_written[fi] && vtx_written[facet_store[fi][9:0]] &&
			vtx_written[facet_store[fi][19:10]] && vtx_written[facet_store[fi][29:20]];
	endfunction

	// One random item: mostly well-formed writes and computes on ready facets.
	task automatic send_random();
		int sel;
		logic [9:0] fi, ca, cb, cc;
		logic [IN_DATA_W-1:0] d;
		bit found;
		sel = $urandom_range(99);
		d = pack_beat($urandom, rand_coord(), rand_coord(), rand_coord(),
			$urandom, $urandom, $urandom, $urandom);
		if (sel < 25) begin
			send_beat(CMD_WR_VERTEX, d);
		end else if (sel < 95) begin
			found = 0;
			if (sel >= 45)
				for (int t = 0; t < 12 && !found; t++) begin
					fi = $urandom;
					found = facet_usable(fi);
				end
			if (found) begin
				d[91:82] = fi;
				send_beat(CMD_COMPUTE, d);
			end else begin
				ca = pick_corner();
				cb = $urandom_range(9) == 0 ? ca : pick_corner();
				cc = pick_corner();
				d[121:92] = {cc, cb, ca};
				send_beat(CMD_WR_FACET, d);
			end
		end else begin
			send_beat(CMD_UNUSED, d);
		end
	endtask

	// Result side: random stalls at the falling edge, checks at the rising edge.
	always @(negedge clk)
		m_tready <= $urandom_range(99) >= r_idle_pct;

	always @(posedge clk) begin
		normal_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
			results_seen++;
			if (m_tuser) degenerate_seen++;
			if (pending_normals.size() == 0) begin
				$display("%0t: unexpected result beat x=%h y=%h z=%h deg=%b",
					$time, got.x, got.y, got.z, got.deg);
				errors++;
			end else begin
				want = pending_normals.pop_front();
				if (got != want) begin
					$display("%0t: normal mismatch expected x=%h y=%h z=%h deg=%b",
						$time, want.x, want.y, want.z, want.deg);
					$display("%0t:                  actual x=%h y=%h z=%h deg=%b",
						$time, got.x, got.y, got.z, got.deg);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= 5000) begin
			$display("Timeout: no beat moved for %0d cycles", stall_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_row(input cmd_t cmd, input logic [9:0] vi,
			input logic [23:0] ea, no, up, input logic [9:0] fi, ca, cb, cc,
			input bit typed = 0, input normal_t want = '0);
		dir_row_t row;
		row = '{cmd, vi, ea, no, up, fi, ca, cb, cc, typed, want};
		dir_rows = {dir_rows, row};
	endtask

	initial begin
		logic [31:0] rs[4];
		trig_reg = '{32'sd0, ONE_Q30, 32'sd0, ONE_Q30};

		// Directed rows under the reset trig values (ECEF x = up, y = east, z = north).
		add_row(CMD_WR_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 1, 256, 0, 0, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 2, 0, 256, 0, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 1023, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 3, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 4, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 5, 1, 0, 0, 0, 0, 0, 0);
		add_row(CMD_WR_VERTEX, 6, 0, 0, 1, 0, 0, 0, 0);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 0, 0, 1, 2);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 1023, 0, 2, 1);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 2, 0, 1023, 3);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 3, 0, 4, 1023);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 4, 1023, 3, 4);
		add_row(CMD_WR_FACET, 0, 0, 0, 0, 5, 0, 5, 6);
		// Upward normal, its reversed winding, repeated corners, collinear corners.
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{32'h4000_0000, 0, 0, 0});
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 1023, 0, 0, 0, 1, '{32'hC000_0000, 0, 0, 0});
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 1, 0, 0, 0, 1, '{0, 0, 0, 1});
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 2, 0, 0, 0, 1, '{0, 0, 0, 1});
		// Unit edges along east and up give a southward normal.
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 5, 0, 0, 0, 1, '{0, 0, 32'hC000_0000, 0});
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 3, 0, 0, 0);
		add_row(CMD_COMPUTE, 0, 0, 0, 0, 4, 0, 0, 0);
		// Unused command with every field bit set: no result.
		add_row(CMD_UNUSED, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].cmd, pack_beat(dir_rows[i].vi, dir_rows[i].ea,
				dir_rows[i].no, dir_rows[i].up, dir_rows[i].fi, dir_rows[i].ca,
				dir_rows[i].cb, dir_rows[i].cc), dir_rows[i].typed, dir_rows[i].want);

		// Random phases, each under its own trig setting, with three idling patterns across them.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: rs = '{$urandom_range(32'h8000_0000) - 32'h4000_0000,
					$urandom_range(32'h8000_0000) - 32'h4000_0000,
					$urandom_range(32'h8000_0000) - 32'h4000_0000,
					$urandom_range(32'h8000_0000) - 32'h4000_0000};
				1: rs = '{32'hC000_0000, 32'h0, 32'h4000_0000, 32'h0};
				2: rs = '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000};
				3: rs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0000, 32'hC000_0000};
				default: rs = '{32'h2D41_3CCD, 32'h2D41_3CCD, $urandom, $urandom};
			endcase
			write_trig(rs[0], rs[1], rs[2], rs[3]);
			if (p >= 4) begin
				s_idle_pct = 0;
				r_idle_pct = 0;
			end else if (p >= 2) begin
				s_idle_pct = 68;
				r_idle_pct = 33;
			end
			for (int i = 0; i < 250; i++) begin
				if (i == 120) begin
					s_tvalid <= 1'b0;
					wait (pending_normals.size() == 0);
					@(negedge clk);
				end
				send_random();
			end
		end

		s_tvalid <= 1'b0;
		wait (pending_normals.size() == 0);
		repeat (250) @(posedge clk);
		$display("Sent %0d beats over 6 trig settings; checked %0d normals (%0d degenerate).",
			items_sent, results_seen, degenerate_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
